// ===== hdl/bir_pkg.sv =====
// Shared types and constants of the bilinear image remap unit.
package bir_pkg;

    localparam int COORD_W    = 10;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int SAMPLE_W   = 20;
    localparam int CMP_W      = SAMPLE_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int CNT_W      = 2;

    localparam int OFIFO_AW    = 3;
    localparam int OFIFO_DEPTH = 1 << OFIFO_AW;
    localparam int PEND_W      = OFIFO_AW + 1;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_COUNT = 2'd2;

    localparam logic [CFG_DATA_W-1:0] SRC_WIDTH_RST  = 11'd1024;
    localparam logic [CFG_DATA_W-1:0] SRC_HEIGHT_RST = 11'd1024;
    localparam logic [CNT_W-1:0]      CHAN_COUNT_RST = 2'd1;

    localparam logic [CNT_W-1:0] CHAN_COUNT_GRAY  = 2'd1;
    localparam logic [CNT_W-1:0] CHAN_COUNT_COLOR = 2'd3;

    typedef enum logic [1:0] {
        CM_NONE,
        CM_GRAY,
        CM_COLOR
    } t_chan_mode;

    typedef struct packed {
        logic [CHAN_W-1:0] chan2;
        logic [CHAN_W-1:0] chan1;
        logic [CHAN_W-1:0] chan0;
        logic              in_img;
    } t_result;

endpackage

// ===== hdl/bir_bank.sv =====
// One bank of the source pixel store: one write port, one registered read port.
module bir_bank
    import bir_pkg::*;
#(
    parameter int AW = 18
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [PIX_W-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [PIX_W-1:0] o_rdata
);

    logic [PIX_W-1:0] r_mem [2**AW];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bilinear_image_remap_unit.sv =====
// Top level of the bilinear image remap unit.
// Input channel (i_in_valid / o_in_stall) carries commands. A write command
// stores one pixel of three 8-bit channels at (write_col, write_row) and
// gives no result. A sample command takes a signed fixed-point coordinate
// and gives one result pixel on the output channel (o_out_valid /
// i_out_stall), plus a flag telling whether the 2x2 neighborhood was inside.
// The pixel store is split into four banks by column and row parity, so the
// four neighbors are read in the same cycle, one per bank.
// A sample passes the stage 0, stage 1 and stage 2 registers, then the queue.
// Throughput: one command per clock, sustained, while the output is taken.
// A result queue of 8 entries follows the pipeline; o_in_stall rises only
// when 8 sample results are in flight or queued, so a stalled receiver
// backs the input up after 8 samples, without loss.
// Configuration writes (o_cfg_ready is always high) are for the user to make
// while idle; the block does not enforce it. Reset clears the pipeline, the
// queue and the registers to their defaults; the pixel store is not cleared and must be written before it is sampled.
module bilinear_image_remap_unit
    import bir_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_cmd,
    input  logic [COORD_W-1:0]           i_write_col,
    input  logic [COORD_W-1:0]           i_write_row,
    input  logic [CHAN_W-1:0]            i_write_chan0,
    input  logic [CHAN_W-1:0]            i_write_chan1,
    input  logic [CHAN_W-1:0]            i_write_chan2,
    input  logic signed [SAMPLE_W-1:0]   i_sample_x,
    input  logic signed [SAMPLE_W-1:0]   i_sample_y,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [CHAN_W-1:0]            o_out_chan0,
    output logic [CHAN_W-1:0]            o_out_chan1,
    output logic [CHAN_W-1:0]            o_out_chan2,
    output logic                         o_inside_res,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int COL_LOG = $clog2((MAX_WIDTH + 1) / 2);
    localparam int ROW_LOG = $clog2((MAX_HEIGHT + 1) / 2);
    localparam int COL_AW  = (COL_LOG > 0) ? COL_LOG : 1;
    localparam int ROW_AW  = (ROW_LOG > 0) ? ROW_LOG : 1;
    localparam int BANK_AW = COL_AW + ROW_AW;
    localparam int W_W     = 2 * FRAC_BITS + 2;
    localparam int P_W     = W_W + CHAN_W;
    localparam int SUM_W   = P_W + 2;
    localparam int V_W     = SUM_W - 2 * FRAC_BITS;

    localparam logic [FRAC_BITS:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [SUM_W-1:0]   HALF = SUM_W'(1) << (2 * FRAC_BITS - 1);
    localparam logic [CMP_W-1:0]   MAXW = CMP_W'(MAX_WIDTH);
    localparam logic [CMP_W-1:0]   MAXH = CMP_W'(MAX_HEIGHT);

    // configuration
    logic [CFG_DATA_W-1:0] r_src_width;
    logic [CFG_DATA_W-1:0] r_src_height;
    logic [CNT_W-1:0]      r_chan_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= SRC_WIDTH_RST;
            r_src_height <= SRC_HEIGHT_RST;
            r_chan_count <= CHAN_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data;
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data;
                CFG_CHAN_COUNT: r_chan_count <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // input transfer and credit for queued results
    logic              in_xfer;
    logic              out_xfer;
    logic [PEND_W-1:0] r_pend;
    logic [PEND_W-1:0] n_pend;

    assign o_in_stall = (r_pend == PEND_W'(OFIFO_DEPTH));
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_comb begin
        n_pend = r_pend;
        if (in_xfer && (i_cmd == CMD_SAMPLE)) begin
            n_pend = n_pend + PEND_W'(1);
        end
        if (out_xfer) begin
            n_pend = n_pend - PEND_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    // stage 0: registered command
    logic                       r_s0_valid;
    logic                       r_s0_cmd;
    logic [COORD_W-1:0]         r_s0_col;
    logic [COORD_W-1:0]         r_s0_row;
    logic [PIX_W-1:0]           r_s0_pix;
    logic signed [SAMPLE_W-1:0] r_s0_x;
    logic signed [SAMPLE_W-1:0] r_s0_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= in_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s0_cmd <= i_cmd;
            r_s0_col <= i_write_col;
            r_s0_row <= i_write_row;
            r_s0_pix <= {i_write_chan2, i_write_chan1, i_write_chan0};
            r_s0_x   <= i_sample_x;
            r_s0_y   <= i_sample_y;
        end
    end

    // stage 0 logic: write decode
    logic [CMP_W-1:0]   wr_col_u;
    logic [CMP_W-1:0]   wr_row_u;
    logic [CMP_W-1:0]   wr_col_h;
    logic [CMP_W-1:0]   wr_row_h;
    logic               wr_ok;
    logic [1:0]         wr_bank;
    logic [BANK_AW-1:0] wr_addr;

    assign wr_col_u = CMP_W'(r_s0_col);
    assign wr_row_u = CMP_W'(r_s0_row);
    assign wr_col_h = wr_col_u >> 1;
    assign wr_row_h = wr_row_u >> 1;
    assign wr_ok    = r_s0_valid && (r_s0_cmd == CMD_WRITE)
                      && (wr_col_u < MAXW) && (wr_row_u < MAXH);
    assign wr_bank  = {r_s0_row[0], r_s0_col[0]};
    assign wr_addr  = {wr_row_h[ROW_AW-1:0], wr_col_h[COL_AW-1:0]};

    // stage 0 logic: sample position, bounds and weights
    logic signed [CMP_W-1:0] x0_s;
    logic signed [CMP_W-1:0] y0_s;
    logic [CMP_W-1:0]        x0_u;
    logic [CMP_W-1:0]        y0_u;
    logic [CMP_W-1:0]        w_eff;
    logic [CMP_W-1:0]        h_eff;
    logic                    nbr_in;
    logic [CMP_W-1:0]        x_even;
    logic [CMP_W-1:0]        x_odd;
    logic [CMP_W-1:0]        y_even;
    logic [CMP_W-1:0]        y_odd;
    logic [FRAC_BITS:0]      fx;
    logic [FRAC_BITS:0]      fy;
    logic [FRAC_BITS:0]      ofx;
    logic [FRAC_BITS:0]      ofy;
    t_chan_mode              mode;

    assign x0_s   = CMP_W'(r_s0_x >>> FRAC_BITS);
    assign y0_s   = CMP_W'(r_s0_y >>> FRAC_BITS);
    assign x0_u   = $unsigned(x0_s);
    assign y0_u   = $unsigned(y0_s);
    assign w_eff  = (CMP_W'(r_src_width) > MAXW) ? MAXW : CMP_W'(r_src_width);
    assign h_eff  = (CMP_W'(r_src_height) > MAXH) ? MAXH : CMP_W'(r_src_height);
    assign nbr_in = !x0_s[CMP_W-1] && !y0_s[CMP_W-1]
                    && ((x0_u + CMP_W'(1)) < w_eff) && ((y0_u + CMP_W'(1)) < h_eff);
    assign x_odd  = x0_u >> 1;
    assign x_even = (x0_u + CMP_W'(1)) >> 1;
    assign y_odd  = y0_u >> 1;
    assign y_even = (y0_u + CMP_W'(1)) >> 1;
    assign fx     = {1'b0, r_s0_x[FRAC_BITS-1:0]};
    assign fy     = {1'b0, r_s0_y[FRAC_BITS-1:0]};
    assign ofx    = ONE - fx;
    assign ofy    = ONE - fy;

    always_comb begin
        case (r_chan_count)
            CHAN_COUNT_GRAY:  mode = CM_GRAY;
            CHAN_COUNT_COLOR: mode = CM_COLOR;
            default:          mode = CM_NONE;
        endcase
    end

    // pixel banks, indexed by {row parity, column parity}
    logic [PIX_W-1:0] rd [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [CMP_W-1:0]   rcol;
        logic [CMP_W-1:0]   rrow;
        logic [BANK_AW-1:0] raddr;

        assign rcol  = ((b & 1) != 0) ? x_odd : x_even;
        assign rrow  = ((b & 2) != 0) ? y_odd : y_even;
        assign raddr = {rrow[ROW_AW-1:0], rcol[COL_AW-1:0]};

        bir_bank #(
            .AW(BANK_AW)
        ) u_bank (
            .i_clk  (i_clk),
            .i_we   (wr_ok && (wr_bank == 2'(b))),
            .i_waddr(wr_addr),
            .i_wdata(r_s0_pix),
            .i_raddr(raddr),
            .o_rdata(rd[b])
        );
    end

    // stage 1: weights beside the bank read data
    logic             r_s1_valid;
    logic             r_s1_inside;
    t_chan_mode       r_s1_mode;
    logic             r_s1_px;
    logic             r_s1_py;
    logic [W_W-1:0]   r_s1_wgt [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= r_s0_valid && (r_s0_cmd == CMD_SAMPLE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_inside <= nbr_in;
        r_s1_mode   <= mode;
        r_s1_px     <= x0_u[0];
        r_s1_py     <= y0_u[0];
        r_s1_wgt[0] <= W_W'(ofx) * W_W'(ofy);
        r_s1_wgt[1] <= W_W'(fx) * W_W'(ofy);
        r_s1_wgt[2] <= W_W'(ofx) * W_W'(fy);
        r_s1_wgt[3] <= W_W'(fx) * W_W'(fy);
    end

    // stage 1 logic: neighbors in order 00, 10, 01, 11
    logic [PIX_W-1:0] nb [4];

    assign nb[0] = rd[{r_s1_py, r_s1_px}];
    assign nb[1] = rd[{r_s1_py, !r_s1_px}];
    assign nb[2] = rd[{!r_s1_py, r_s1_px}];
    assign nb[3] = rd[{!r_s1_py, !r_s1_px}];

    // stage 2: weighted products
    logic           r_s2_valid;
    logic           r_s2_inside;
    t_chan_mode     r_s2_mode;
    logic [P_W-1:0] r_prod [3][4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_inside <= r_s1_inside;
        r_s2_mode   <= r_s1_mode;
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 4; k++) begin
                r_prod[c][k] <= P_W'(r_s1_wgt[k]) * P_W'(nb[k][c*CHAN_W +: CHAN_W]);
            end
        end
    end

    // stage 2 logic: sum, round half up, saturate, select
    logic [SUM_W-1:0]  sum [3];
    logic [V_W-1:0]    val [3];
    logic [CHAN_W-1:0] sat [3];
    t_result           res;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum[c] = SUM_W'(r_prod[c][0]) + SUM_W'(r_prod[c][1])
                   + SUM_W'(r_prod[c][2]) + SUM_W'(r_prod[c][3]) + HALF;
            val[c] = sum[c][SUM_W-1:2*FRAC_BITS];
            sat[c] = (val[c] > V_W'(255)) ? 8'd255 : val[c][CHAN_W-1:0];
        end
    end

    always_comb begin
        res        = '0;
        res.in_img = r_s2_inside;
        if (r_s2_inside) begin
            case (r_s2_mode)
                CM_GRAY: begin
                    res.chan0 = sat[0];
                end
                CM_COLOR: begin
                    res.chan0 = sat[0];
                    res.chan1 = sat[1];
                    res.chan2 = sat[2];
                end
                default: ;
            endcase
        end
    end

    // result queue
    t_result             r_fifo [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0] r_wptr;
    logic [OFIFO_AW-1:0] r_rptr;
    logic [PEND_W-1:0]   r_fcnt;

    assign o_out_valid = (r_fcnt != '0);
    assign out_xfer    = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_fifo[r_wptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fcnt <= '0;
        end else begin
            if (r_s2_valid) begin
                r_wptr <= r_wptr + OFIFO_AW'(1);
            end
            if (out_xfer) begin
                r_rptr <= r_rptr + OFIFO_AW'(1);
            end
            r_fcnt <= r_fcnt + PEND_W'(r_s2_valid) - PEND_W'(out_xfer);
        end
    end

    assign o_out_chan0  = r_fifo[r_rptr].chan0;
    assign o_out_chan1  = r_fifo[r_rptr].chan1;
    assign o_out_chan2  = r_fifo[r_rptr].chan2;
    assign o_inside_res = r_fifo[r_rptr].in_img;

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PEND_W'(OFIFO_DEPTH))
        else $error("result credit count above queue depth");

    a_queue_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= r_pend)
        else $error("queued results exceed outstanding samples");

    a_valid_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pend != '0))
        else $error("result offered with no outstanding sample");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_inside_res) |->
            (o_out_chan0 == '0 && o_out_chan1 == '0 && o_out_chan2 == '0))
        else $error("outside sample with nonzero channels");

endmodule
